[rtl/ssc_pkg.sv]
// shared types and constants for the signed sort block
// used by ssc_cell and signed_sort_by_sign_class; no dependencies
package ssc_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;

    typedef logic signed [VAL_W-1:0] t_value;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the new value in order
        logic shift;  // move every value one cell toward cell 0
    } t_cell_ctrl;

    // what a cell shows its neighbors
    typedef struct packed {
        t_value val;
        logic   occ;
        logic   gt;   // cell is empty or holds a value above the new one
    } t_cell_link;

endpackage

[rtl/ssc_cell.sv]
// one cell of the insertion sort chain: holds one value and its occupied bit
// depends on ssc_pkg
module ssc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssc_pkg::t_cell_ctrl i_ctrl,
    input  ssc_pkg::t_value    i_new,
    input  ssc_pkg::t_cell_link i_left,
    input  ssc_pkg::t_cell_link i_right,
    output ssc_pkg::t_cell_link o_link
);
    import ssc_pkg::*;

    t_value r_val;
    logic   r_occ;
    logic   w_gt;

    assign w_gt   = !r_occ || (r_val > i_new);
    assign o_link = '{val: r_val, occ: r_occ, gt: w_gt};

    // value: insert from left neighbor or new item, or shift from right neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && w_gt) begin
            r_val <= i_left.gt ? i_left.val : i_new;
        end else if (i_ctrl.shift) begin
            r_val <= i_right.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctrl.ins && w_gt) begin
            r_occ <= r_occ | i_left.occ;
        end else if (i_ctrl.shift) begin
            r_occ <= i_right.occ;
        end
    end

endmodule

[rtl/signed_sort_by_sign_class.sv]
// top level of the signed sort block: a row of CAPACITY sort cells and the
// fill / drain control; depends on ssc_pkg and ssc_cell
//
//  channel   direction  fields (tdata / tlast / tuser)
//  s_axis    in         value[31:0] / last / -
//  m_axis    out        sorted_value[31:0] / end_of_list / overflow
//
// fill: one item per cycle, each inserted in order across the cell row in the
// cycle it is accepted (one compare per cell against the broadcast value);
// an item accepted while the row is full is dropped and sets the overflow flag
// drain: after the last item, one result per cycle while m_axis is ready, from
// cell 0 as the row shifts toward it; s_axis is not ready until the final
// result is taken, and the next list may start in the cycle after that
// reset clears the occupied bits, drain mode and the overflow flag
// m_axis stalls hold the row in place; the result shown is a register
module signed_sort_by_sign_class (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [31:0]          i_s_axis_tdata,   // [31:0] value
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [31:0]          o_m_axis_tdata,   // [31:0] sorted_value
    output logic                 o_m_axis_tlast,
    output logic [0:0]           o_m_axis_tuser    // [0] overflow
);
    import ssc_pkg::*;

    logic        r_drain;
    logic        r_drop;
    t_cell_ctrl  w_ctrl;
    t_value      w_new;
    t_cell_link  w_link [CAPACITY];
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_full;
    logic        w_end;
    logic [CAPACITY-1:0] w_occ;

    assign w_new     = t_value'(i_s_axis_tdata);
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_full    = w_link[CAPACITY-1].occ;
    assign w_end     = !w_link[1].occ;

    assign w_ctrl = '{ins: w_in_acc && !w_full, shift: w_out_acc};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_cell_link w_l;
            t_cell_link w_r;
            if (gi == 0) begin : g_first
                assign w_l = '{val: '0, occ: 1'b1, gt: 1'b0};
            end else begin : g_mid
                assign w_l = w_link[gi-1];
            end
            if (gi == CAPACITY-1) begin : g_last
                assign w_r = '{val: '0, occ: 1'b0, gt: 1'b1};
            end else begin : g_inner
                assign w_r = w_link[gi+1];
            end
            ssc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_new   (w_new),
                .i_left  (w_l),
                .i_right (w_r),
                .o_link  (w_link[gi])
            );
            assign w_occ[gi] = w_link[gi].occ;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            if (w_in_acc && w_full) begin
                r_drop <= 1'b1;
            end
            if (w_in_acc && i_s_axis_tlast) begin
                r_drain <= 1'b1;
            end
            if (w_out_acc && w_end) begin
                r_drain <= 1'b0;
                r_drop  <= 1'b0;
            end
        end
    end

    assign o_s_axis_tready = !r_drain;
    assign o_m_axis_tvalid = r_drain;
    assign o_m_axis_tdata  = w_link[0].val;
    assign o_m_axis_tlast  = w_end;
    assign o_m_axis_tuser  = r_drop;

    // occupied cells always form a prefix of the row
    generate
        for (gi = 0; gi < CAPACITY-1; gi++) begin : g_chk
            a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_occ[gi+1] |-> w_occ[gi])
                else $error("occupied cells not contiguous");
        end
    endgenerate

    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> w_occ[0])
        else $error("drain with empty cell 0");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !w_end) |=> ($signed(o_m_axis_tdata) >= $signed($past(o_m_axis_tdata))))
        else $error("results out of order");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_end) |=> (w_occ == '0 && !r_drop))
        else $error("row not empty after end of list");

endmodule
